[design/jsu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int CapWidth = 16;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_QUOTE = 2'd1;
  localparam logic [1:0] STAT_BAD_ESC  = 2'd2;
  localparam logic [1:0] STAT_OPEN_ESC = 2'd3;

  localparam logic REG_OUT_CAPACITY = 1'b0;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data;
    logic [1:0] status;
    logic       dropped;
    logic       done;
  } jsu_result_t;

endpackage

[design/jsu_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_core
// Decode state and per-byte decode logic; state advances on step.
// ----------------------------------------------------------------------------
module jsu_core
  import jsu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic [CapWidth-1:0] capacity,
  output jsu_result_t         res
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SUBST  = 8'h5F;

  typedef enum logic [2:0] {
    MODE_START,
    MODE_BODY,
    MODE_ESC,
    MODE_HEX,
    MODE_ERR1,
    MODE_ERR2
  } mode_t;

  mode_t               mode;
  mode_t               mode_next;
  logic [1:0]          hex_count;
  logic [1:0]          hex_count_next;
  logic [15:0]         code_value;
  logic [15:0]         code_value_next;
  logic [CapWidth-1:0] produced_count;
  logic [CapWidth-1:0] produced_count_next;

  logic                emit_req;
  logic [7:0]          emit_val;
  logic [15:0]         code_shift;
  logic [CapWidth-1:0] cap_lim;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) d = c[3:0];
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      d = c[3:0] + 4'd9;
    return d;
  endfunction

  assign code_shift = {code_value[11:0], hex_digit(in_byte)};
  assign cap_lim    = (capacity == '0) ? '0 : capacity - 1'b1;

  always_comb begin
    mode_next           = mode;
    hex_count_next      = hex_count;
    code_value_next     = code_value;
    produced_count_next = produced_count;
    emit_req            = 1'b0;
    emit_val            = 8'h00;
    res                 = '0;

    unique case (mode)
      MODE_START: begin
        mode_next = (in_byte == CH_QUOTE) ? MODE_BODY : MODE_ERR1;
      end
      MODE_BODY: begin
        if (in_byte == CH_BSLASH) begin
          mode_next = MODE_ESC;
        end else if (in_byte != CH_QUOTE) begin
          emit_req = 1'b1;
          emit_val = in_byte;
        end
      end
      MODE_ESC: begin
        mode_next = MODE_BODY;
        unique case (in_byte)
          CH_BSLASH: begin emit_req = 1'b1; emit_val = CH_BSLASH; end
          CH_QUOTE:  begin emit_req = 1'b1; emit_val = CH_QUOTE;  end
          CH_B:      begin emit_req = 1'b1; emit_val = 8'h08;     end
          CH_F:      begin emit_req = 1'b1; emit_val = 8'h0C;     end
          CH_N:      begin emit_req = 1'b1; emit_val = 8'h0A;     end
          CH_R:      begin emit_req = 1'b1; emit_val = 8'h0D;     end
          CH_T:      begin emit_req = 1'b1; emit_val = 8'h09;     end
          CH_U: begin
            mode_next       = MODE_HEX;
            hex_count_next  = 2'd0;
            code_value_next = 16'h0000;
          end
          default: mode_next = MODE_ERR2;
        endcase
      end
      MODE_HEX: begin
        if (hex_count == 2'd3) begin
          emit_req = 1'b1;
          emit_val = (code_shift == 16'h0000 || code_shift[15:8] != 8'h00) ?
                     CH_SUBST : code_shift[7:0];
          hex_count_next  = 2'd0;
          code_value_next = 16'h0000;
          mode_next       = MODE_BODY;
        end else begin
          code_value_next = code_shift;
          hex_count_next  = hex_count + 2'd1;
        end
      end
      default: begin
      end
    endcase

    if (emit_req) begin
      if (produced_count < cap_lim) begin
        res.byte_valid      = 1'b1;
        res.data            = emit_val;
        produced_count_next = produced_count + 1'b1;
      end else begin
        res.dropped = 1'b1;
      end
    end

    priority if (mode_next == MODE_ERR1) res.status = STAT_NO_QUOTE;
    else if (mode_next == MODE_ERR2) res.status = STAT_BAD_ESC;
    else if (in_last && (mode_next == MODE_ESC || mode_next == MODE_HEX))
      res.status = STAT_OPEN_ESC;
    else res.status = STAT_OK;

    res.done = in_last;

    if (in_last) begin
      mode_next           = MODE_START;
      hex_count_next      = 2'd0;
      code_value_next     = 16'h0000;
      produced_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_START;
      hex_count      <= 2'd0;
      code_value     <= 16'h0000;
      produced_count <= '0;
    end else if (step) begin
      mode           <= mode_next;
      hex_count      <= hex_count_next;
      code_value     <= code_value_next;
      produced_count <= produced_count_next;
    end
  end

endmodule

[design/json_string_unescape.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape
// Decodes a quoted JSON string, one source byte per beat, one result per beat.
// ----------------------------------------------------------------------------
// One result beat per input beat, at one beat per cycle sustained while
// results are not stalled. A byte is held in the input register, decoded
// combinationally against the decode state, and lands in the result
// register; a stalled result holds the input register.
// The decode state updates as a byte moves into the result register, so the
// per-byte decode path bounds the clock. The user must write out_capacity
// (address 0) only while no beat is in flight; the block does not enforce it.
module json_string_unescape
  import jsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic [1:0]  status,
  output logic        dropped,
  output logic        done_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CapWidth-1:0] out_capacity;
  logic                s1_valid;
  logic [7:0]          s1_byte;
  logic                s1_last;
  logic                out_load;
  logic                s1_adv;
  logic                in_take;
  jsu_result_t         res;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_OUT_CAPACITY) ?
                    {{(32-CapWidth){1'b0}}, out_capacity} : 32'h0;

  assign out_load = !res_valid || res_ready;
  assign s1_adv   = s1_valid && out_load;
  assign in_ready = !s1_valid || s1_adv;
  assign in_take  = in_valid && in_ready;

  jsu_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_adv),
    .in_byte  (s1_byte),
    .in_last  (s1_last),
    .capacity (out_capacity),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= '1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_OUT_CAPACITY) begin
      out_capacity <= pwdata[CapWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (in_take) begin
      s1_byte <= in_byte;
      s1_last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= s1_valid;
    end
    if (s1_adv) begin
      out_valid <= res.byte_valid;
      out_byte  <= res.data;
      status    <= res.status;
      dropped   <= res.dropped;
      done_res  <= res.done;
    end
  end

`ifndef SYNTHESIS
  a_drop_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid && dropped |-> !out_valid && status == STAT_OK)
    else $error("dropped beat also carries a byte or an error");

  a_open_esc_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == STAT_OPEN_ESC |-> done_res && !out_valid)
    else $error("open escape status on a non-final or byte-carrying beat");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_byte) && $stable(s1_last))
    else $error("input stage lost or changed a stalled byte");
`endif

endmodule
